[rtl/core/nearest_target_pursuit_defines.svh]
// Assertion macros for the nearest target pursuit block
`ifndef NEAREST_TARGET_PURSUIT_DEFINES_SVH
`define NEAREST_TARGET_PURSUIT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define NTP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntp check failed");

// Next-cycle implication checked outside reset
`define NTP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntp check failed");

`endif

[rtl/core/ntp_pkg.sv]
// ----------------------------------------------------------------------------
// ntp_pkg
// Types, constants and the arctangent table for the pursuit controller.
// ----------------------------------------------------------------------------
package ntp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 8;
  localparam int CW           = 28;   // CORDIC x/y width
  localparam int ZW           = 28;   // angle accumulator width
  localparam int SW           = $clog2(CORDIC_STEPS + 1);

  localparam logic signed [ZW-1:0] PI_Q24     = ZW'(52707179);
  localparam logic signed [ZW-1:0] TWO_PI_Q24 = ZW'(105414357);
  localparam logic [29:0]          INV_GAIN   = 30'd652032874;
  localparam logic [14:0]          SPEED_MAX  = 15'd32767;
  localparam logic signed [15:0]   TURN_LIMIT = 16'sd25736;

  localparam logic [1:0] MODE_T1   = 2'd0;
  localparam logic [1:0] MODE_T2   = 2'd1;
  localparam logic [1:0] MODE_POSE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_ROT, ST_MUL, ST_OUT
  } ntp_state_t;

  // control bundle from the sequencer to the CORDIC unit
  typedef struct packed {
    logic load;
    logic step;
  } ntp_cordic_ctl_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0:  atan_q24 = ZW'(13176795);
      5'd1:  atan_q24 = ZW'(7778716);
      5'd2:  atan_q24 = ZW'(4110060);
      5'd3:  atan_q24 = ZW'(2086331);
      5'd4:  atan_q24 = ZW'(1047214);
      5'd5:  atan_q24 = ZW'(524117);
      5'd6:  atan_q24 = ZW'(262123);
      5'd7:  atan_q24 = ZW'(131069);
      5'd8:  atan_q24 = ZW'(65536);
      5'd9:  atan_q24 = ZW'(32768);
      5'd10: atan_q24 = ZW'(16384);
      5'd11: atan_q24 = ZW'(8192);
      5'd12: atan_q24 = ZW'(4096);
      5'd13: atan_q24 = ZW'(2048);
      5'd14: atan_q24 = ZW'(1024);
      5'd15: atan_q24 = ZW'(512);
      5'd16: atan_q24 = ZW'(256);
      5'd17: atan_q24 = ZW'(128);
      5'd18: atan_q24 = ZW'(64);
      5'd19: atan_q24 = ZW'(32);
      5'd20: atan_q24 = ZW'(16);
      5'd21: atan_q24 = ZW'(8);
      5'd22: atan_q24 = ZW'(4);
      5'd23: atan_q24 = ZW'(2);
      default: atan_q24 = '0;
    endcase
  endfunction

endpackage

[rtl/core/nearest_target_pursuit.sv]
// ----------------------------------------------------------------------------
// nearest_target_pursuit
// Drive command toward the nearer of two stored targets.
// ----------------------------------------------------------------------------
// Target updates (mode 0/1) load the target registers on acceptance. A pose
// request (mode 2) runs from acceptance to result through a squared-distance
// compare, one target per cycle on a pair of 17x17 squarers, one pre-rotation,
// one micro-rotation per cycle in the iterated CORDIC unit, then a gain
// multiply state and an output state that waits while the result side stalls
// a waiting result. One request is in flight at a time; the sequencer is
// freed once the result register is loaded, so a new pose request is taken
// only after the previous result has been loaded.
module nearest_target_pursuit import ntp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        out_linear_speed,
  output logic signed [15:0] out_turn_rate,
  output logic               out_chose_second,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data
);

  ntp_state_t state_r, state_nxt;
  logic [14:0] offset_r;
  logic signed [15:0] t1x_r, t1y_r, t2x_r, t2y_r;
  logic signed [15:0] px_r, py_r, hd_r;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [33:0] d1_r;
  logic second_r;
  logic signed [16:0] dx_r, dy_r;
  logic in_acc;
  ntp_cordic_ctl_t cctl;
  logic [CW-1:0] mag_x;
  logic signed [ZW-1:0] ang;
  logic [CW+29:0] prod_r;
  logic signed [ZW-1:0] err_r;
  logic out_load;

  logic signed [16:0] ax, ay, bx, by, ux, uy;
  logic [33:0] dsq;

  assign ax = 17'(t1x_r) - 17'(px_r);
  assign ay = 17'(t1y_r) - 17'(py_r);
  assign bx = 17'(t2x_r) - 17'(px_r);
  assign by = 17'(t2y_r) - 17'(py_r);
  // one squared distance per cycle
  assign ux  = (cnt_r[0] == 1'b0) ? ax : bx;
  assign uy  = (cnt_r[0] == 1'b0) ? ay : by;
  assign dsq = 34'(ux * ux) + 34'(uy * uy);

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      offset_r <= 15'd2048;
      t1x_r <= '0; t1y_r <= '0; t2x_r <= '0; t2y_r <= '0;
      cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) offset_r <= cfg_data;
      if (in_acc && in_mode == MODE_T1) begin
        t1x_r <= in_pos_x; t1y_r <= in_pos_y;
      end
      if (in_acc && in_mode == MODE_T2) begin
        t2x_r <= in_pos_x; t2y_r <= in_pos_y;
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cctl      = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc && in_mode == MODE_POSE) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[0]) begin
          state_nxt = ST_ROT;
          cnt_nxt   = '0;
        end
      end
      ST_ROT: begin
        if (cnt_r == '0) cctl.load = 1'b1;
        else cctl.step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SW'(CORDIC_STEPS)) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_pos_x; py_r <= in_pos_y; hd_r <= in_heading;
    end
    if (state_r == ST_SQ) begin
      if (!cnt_r[0]) d1_r <= dsq;
      else begin
        second_r <= (dsq < d1_r);
        dx_r <= (dsq < d1_r) ? bx : ax;
        dy_r <= (dsq < d1_r) ? by : ay;
      end
    end
    if (state_r == ST_MUL) begin
      prod_r <= (CW+30)'(mag_x) * (CW+30)'(INV_GAIN) + ((CW+30)'(1) << 37);
      err_r  <= ang - (ZW'(hd_r) <<< 11);
    end
  end

  logic [4:0] step_idx;
  assign step_idx = 5'(cnt_r - 1'b1);

  ntp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl(cctl), .step_idx(step_idx),
    .dx(dx_r), .dy(dy_r), .mag_x(mag_x), .ang(ang)
  );

  // output stage: range offset, angle wrap and clamps
  logic zero_vec;
  logic [CW-1:0] mag;
  logic [CW:0] sp;
  logic signed [ZW-1:0] werr, tr_full;
  logic signed [15:0] tr;
  assign zero_vec = (dx_r == '0) && (dy_r == '0);
  assign mag = zero_vec ? '0 : CW'(prod_r >> 38);
  assign sp  = (mag > CW'(offset_r)) ? (CW+1)'(mag) - (CW+1)'(offset_r) : '0;

  always_comb begin
    werr = zero_vec ? -(ZW'(hd_r) <<< 11) : err_r;
    if (werr > PI_Q24) werr = werr - TWO_PI_Q24;
    else if (werr < -PI_Q24) werr = werr + TWO_PI_Q24;
    tr_full = (werr + ZW'(1024)) >>> 11;
    if (tr_full > ZW'(TURN_LIMIT)) tr = TURN_LIMIT;
    else if (tr_full < -ZW'(TURN_LIMIT)) tr = -TURN_LIMIT;
    else tr = 16'(tr_full);
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_linear_speed <= (sp > (CW+1)'(SPEED_MAX)) ? SPEED_MAX : 15'(sp);
      out_turn_rate    <= tr;
      out_chose_second <= second_r;
    end
  end

endmodule

[rtl/core/ntp_cordic.sv]
// ----------------------------------------------------------------------------
// ntp_cordic
// Iterated CORDIC vectoring unit, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ntp_cordic import ntp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ntp_cordic_ctl_t        ctl,
  input  logic [4:0]             step_idx,
  input  logic signed [16:0]     dx,
  input  logic signed [16:0]     dy,
  output logic [CW-1:0]          mag_x,
  output logic signed [ZW-1:0]   ang
);

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, gx, gy;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [CW-1:0] xs, ys;

  assign gx = {{(CW-17-GUARD_BITS){dx[16]}}, dx, {GUARD_BITS{1'b0}}};
  assign gy = {{(CW-17-GUARD_BITS){dy[16]}}, dy, {GUARD_BITS{1'b0}}};
  assign xs = x_r >>> step_idx;
  assign ys = y_r >>> step_idx;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (ctl.load) begin
      if (gx < 0) begin
        // pre-rotate into the right half plane
        x_nxt = -gx;
        y_nxt = -gy;
        z_nxt = (gy >= 0) ? PI_Q24 : -PI_Q24;
      end else begin
        x_nxt = gx;
        y_nxt = gy;
        z_nxt = '0;
      end
    end else if (ctl.step) begin
      if (y_r < 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_q24(step_idx);
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_q24(step_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign mag_x = x_r;
  assign ang   = z_r;

endmodule

[rtl/core/ntp_checker.sv]
// ----------------------------------------------------------------------------
// ntp_checker
// Port-level checks on the pursuit controller.
// ----------------------------------------------------------------------------
`include "nearest_target_pursuit_defines.svh"
module ntp_checker import ntp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic [14:0]        out_linear_speed,
  input logic signed [15:0] out_turn_rate
);

  `NTP_ASSERT_IMP(a_turn_hi, out_valid, out_turn_rate <= TURN_LIMIT)
  `NTP_ASSERT_IMP(a_turn_lo, out_valid, out_turn_rate >= -TURN_LIMIT)
  `NTP_ASSERT_NXT(a_pose_busy, in_valid && !in_stall && in_mode == MODE_POSE, in_stall)
  `NTP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_turn_rate) && $stable(out_linear_speed))

endmodule

bind nearest_target_pursuit ntp_checker u_ntp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_mode(in_mode), .out_valid(out_valid), .out_stall(out_stall),
  .out_linear_speed(out_linear_speed), .out_turn_rate(out_turn_rate)
);
